// File: hw/rtl/tst_pkg.sv
// Shared types and constants of the TCP session tracker.
package tst_pkg;

  localparam logic [7:0] FL_FIN = 8'h01;
  localparam logic [7:0] FL_SYN = 8'h02;
  localparam logic [7:0] FL_RST = 8'h04;
  localparam logic [7:0] FL_ACK = 8'h10;
  localparam logic [7:0] FL_KEEP = FL_FIN | FL_SYN | FL_RST | FL_ACK;

  typedef enum logic [2:0] {
    HS_UNKNOWN     = 3'd0,
    HS_SYN_SENT    = 3'd1,
    HS_SYNACK_SENT = 3'd2,
    HS_ESTABLISHED = 3'd3,
    HS_CLOSING     = 3'd4,
    HS_CLOSED      = 3'd5
  } tst_hs_t;

  typedef enum logic [1:0] {
    CHK_NO_BASE  = 2'd0,
    CHK_IN_ORDER = 2'd1,
    CHK_MISMATCH = 2'd2
  } tst_chk_t;

  // One slot of the session table as it sits in memory.
  typedef struct packed {
    logic        valid;
    tst_hs_t     hs;
    logic        client_orient;
    logic        closer_is_client;
    logic        client_has_base;
    logic [31:0] client_base;
    logic [31:0] client_next;
    logic        server_has_base;
    logic [31:0] server_base;
    logic [31:0] server_next;
    logic [31:0] start_time;
    logic [63:0] session_number;
    logic [31:0] round_trip;
  } tst_entry_t;

  localparam int ENTRY_W = $bits(tst_entry_t);

  // Segment fields held between the memory read and the update.
  typedef struct packed {
    logic        orientation;
    logic [7:0]  tcp_flags;
    logic [31:0] seq_number;
    logic [15:0] segment_length;
    logic [31:0] time_us;
  } tst_seg_t;

  typedef struct packed {
    logic        session_found;
    logic        new_session;
    logic [63:0] session_id;
    logic [2:0]  status;
    logic [1:0]  seq_check;
    logic [31:0] rtt_us;
  } tst_result_t;

  // Control outcome of one update, passed back to the top level.
  typedef struct packed {
    logic write;
    logic created;
  } tst_upd_ctl_t;

endpackage

// File: hw/rtl/tst_if.sv
// Request channels of the TCP session tracker: segments in, results out.
interface tst_seg_if;
  logic        valid;
  logic        ready;
  logic [9:0]  session_slot;
  logic        orientation;
  logic [7:0]  tcp_flags;
  logic [31:0] seq_number;
  logic [15:0] segment_length;
  logic [31:0] time_us;

  modport source (output valid, session_slot, orientation, tcp_flags, seq_number,
                  segment_length, time_us, input ready);
  modport sink (input valid, session_slot, orientation, tcp_flags, seq_number,
                segment_length, time_us, output ready);
endinterface

interface tst_res_if;
  logic        valid;
  logic        ready;
  logic        session_found;
  logic        new_session;
  logic [63:0] session_id;
  logic [2:0]  status;
  logic [1:0]  seq_check;
  logic [31:0] rtt_us;

  modport source (output valid, session_found, new_session, session_id, status,
                  seq_check, rtt_us, input ready);
  modport sink (input valid, session_found, new_session, session_id, status,
                seq_check, rtt_us, output ready);
endinterface

// File: hw/rtl/tcp_session_tracker_top.sv
// TCP session tracker: slot table of sessions updated once per segment request.
//
// Each accepted segment request reads its slot (session_slot modulo SESSION_SLOTS)
// from a single table memory with a registered read port, updates it in the
// update stage and writes it back as that stage advances, when its result is also
// loaded into the output register. While the result channel does not stall, a new
// segment can be accepted every cycle, so one request per cycle is sustained.
// When two consecutive requests hit the same slot, the entry just written is
// forwarded to the second one in place of the stale memory data. Back-pressure on
// the result channel stalls the update stage; outside the clearing pass the input
// is held off only while that stage is blocked. After reset the block clears the
// valid bits of the table, one slot per cycle, and accepts no segment until that
// pass ends. An empty slot is claimed only by a bare SYN, which draws the
// next number from a 64-bit session counter; other requests to an empty slot
// return a result with every field zero.
module tcp_session_tracker_top import tst_pkg::*; #(
  parameter int SESSION_SLOTS = 1024
) (
  input logic        clk,
  input logic        rst,
  tst_seg_if.sink    seg,
  tst_res_if.source  res
);

  localparam int SLOT_W = $clog2(SESSION_SLOTS);

  // Reduce the incoming slot modulo the table size by shifted compare and subtract.
  function automatic logic [SLOT_W-1:0] slot_reduce(input logic [9:0] raw);
    logic [10:0] v;
    v = {1'b0, raw};
    for (int k = 9; k >= 0; k--) begin
      if ((SESSION_SLOTS << k) <= int'(v)) begin
        v = v - 11'(SESSION_SLOTS << k);
      end
    end
    return SLOT_W'(v);
  endfunction

  // Clearing pass after reset.
  logic              clr_busy;
  logic [SLOT_W-1:0] clr_addr;

  // Update stage, loaded from the accepted request.
  logic              b_valid;
  logic [SLOT_W-1:0] b_slot;
  tst_seg_t          b_seg;
  logic              b_go;

  // Forwarding of a write that lands on the slot being read in the same cycle.
  logic              fwd_hit;
  tst_entry_t        fwd_entry;

  logic [63:0]       counter;

  logic              accept;
  logic [SLOT_W-1:0] in_slot;
  logic [ENTRY_W-1:0] rd_data;
  tst_entry_t        cur_entry;
  tst_entry_t        upd_entry;
  tst_result_t       upd_result;
  tst_upd_ctl_t      upd_ctl;

  logic              wr_en;
  logic [SLOT_W-1:0] wr_addr;
  tst_entry_t        wr_entry;
  logic              upd_wr;

  assign b_go      = !res.valid || res.ready;
  assign seg.ready = !clr_busy && (!b_valid || b_go);
  assign accept    = seg.valid && seg.ready;
  assign in_slot   = slot_reduce(seg.session_slot);

  assign cur_entry = fwd_hit ? fwd_entry : tst_entry_t'(rd_data);
  assign upd_wr    = b_valid && b_go && upd_ctl.write;

  always_comb begin
    if (clr_busy) begin
      wr_en    = 1'b1;
      wr_addr  = clr_addr;
      wr_entry = '0;
    end else begin
      wr_en    = upd_wr;
      wr_addr  = b_slot;
      wr_entry = upd_entry;
    end
  end

  tst_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (SESSION_SLOTS)
  ) u_table (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_entry),
    .rd_en   (accept),
    .rd_addr (in_slot),
    .rd_data (rd_data)
  );

  tst_update u_update (
    .entry      (cur_entry),
    .seg        (b_seg),
    .counter    (counter),
    .entry_next (upd_entry),
    .result     (upd_result),
    .ctl        (upd_ctl)
  );

  // Control state: clearing pass, stage valid, counter and output valid.
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_busy  <= 1'b1;
      clr_addr  <= '0;
      b_valid   <= 1'b0;
      counter   <= '0;
      res.valid <= 1'b0;
    end else begin
      if (clr_busy) begin
        clr_addr <= clr_addr + SLOT_W'(1);
        if (clr_addr == SLOT_W'(SESSION_SLOTS - 1)) begin
          clr_busy <= 1'b0;
        end
      end
      if (accept) begin
        b_valid <= 1'b1;
      end else if (b_go) begin
        b_valid <= 1'b0;
      end
      if (b_valid && b_go && upd_ctl.created) begin
        counter <= counter + 64'd1;
      end
      if (b_go) begin
        res.valid <= b_valid;
      end
    end
  end

  // Payload registers of the update stage and the result.
  always_ff @(posedge clk) begin
    if (accept) begin
      b_slot              <= in_slot;
      b_seg.orientation   <= seg.orientation;
      b_seg.tcp_flags     <= seg.tcp_flags;
      b_seg.seq_number    <= seg.seq_number;
      b_seg.segment_length <= seg.segment_length;
      b_seg.time_us       <= seg.time_us;
      fwd_hit             <= upd_wr && (b_slot == in_slot);
      fwd_entry           <= upd_entry;
    end
    if (b_valid && b_go) begin
      res.session_found <= upd_result.session_found;
      res.new_session   <= upd_result.new_session;
      res.session_id    <= upd_result.session_id;
      res.status        <= upd_result.status;
      res.seq_check     <= upd_result.seq_check;
      res.rtt_us        <= upd_result.rtt_us;
    end
  end

endmodule

// File: hw/rtl/tst_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
module tst_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// File: hw/rtl/tst_update.sv
// Per-segment update of one session slot: claim, sequence check and handshake.
module tst_update import tst_pkg::*; (
  input  tst_entry_t   entry,
  input  tst_seg_t     seg,
  input  logic [63:0]  counter,
  output tst_entry_t   entry_next,
  output tst_result_t  result,
  output tst_upd_ctl_t ctl
);

  logic [7:0]  flags;
  logic        created;
  logic        from_client;
  logic        has;
  logic [31:0] base;
  logic [31:0] nxt;
  logic [31:0] rel;
  logic        hit;
  logic        fin;
  logic        bump;
  logic [31:0] nxt_new;
  tst_chk_t    chk;
  tst_entry_t  e;

  always_comb begin
    flags   = seg.tcp_flags & FL_KEEP;
    created = !entry.valid && (flags == FL_SYN);
    e       = entry;
    if (created) begin
      e                = '0;
      e.valid          = 1'b1;
      e.hs             = HS_UNKNOWN;
      e.client_orient  = seg.orientation;
      e.session_number = counter + 64'd1;
    end

    from_client = (seg.orientation == e.client_orient);
    has  = from_client ? e.client_has_base : e.server_has_base;
    base = from_client ? e.client_base : e.server_base;
    nxt  = from_client ? e.client_next : e.server_next;
    rel  = seg.seq_number - base;
    hit  = has && (rel == nxt);
    if (!has) begin
      chk = CHK_NO_BASE;
    end else if (hit) begin
      chk = CHK_IN_ORDER;
    end else begin
      chk = CHK_MISMATCH;
    end

    // A FIN that moves the close sequence on consumes one sequence number.
    fin  = (flags & FL_FIN) != 8'h00;
    bump = fin && ((e.hs == HS_ESTABLISHED) ||
                   ((e.hs == HS_CLOSING) && (e.closer_is_client != from_client)));
    nxt_new = nxt + (hit ? {16'h0000, seg.segment_length} : 32'h0) + {31'b0, bump};
    if (from_client) begin
      e.client_next = nxt_new;
    end else begin
      e.server_next = nxt_new;
    end

    unique case (e.hs)
      HS_UNKNOWN: begin
        if ((flags == FL_SYN) && from_client) begin
          e.hs              = HS_SYN_SENT;
          e.start_time      = seg.time_us;
          e.client_has_base = 1'b1;
          e.client_base     = seg.seq_number;
          e.client_next     = 32'd1 + {16'h0000, seg.segment_length};
        end
      end
      HS_SYN_SENT: begin
        if ((flags == (FL_SYN | FL_ACK)) && !from_client) begin
          e.hs              = HS_SYNACK_SENT;
          e.server_has_base = 1'b1;
          e.server_base     = seg.seq_number;
          e.server_next     = 32'd1 + {16'h0000, seg.segment_length};
        end
      end
      HS_SYNACK_SENT: begin
        if ((flags == FL_ACK) && from_client) begin
          e.hs         = HS_ESTABLISHED;
          e.round_trip = seg.time_us - e.start_time;
        end
      end
      HS_ESTABLISHED: begin
        if (fin) begin
          e.hs               = HS_CLOSING;
          e.closer_is_client = from_client;
        end
      end
      HS_CLOSING: begin
        if (bump) begin
          e.hs = HS_CLOSED;
        end
      end
      default: ;
    endcase

    entry_next  = e;
    ctl.write   = e.valid;
    ctl.created = created;

    if (!e.valid) begin
      result = '0;
    end else begin
      result.session_found = 1'b1;
      result.new_session   = created;
      result.session_id    = e.session_number;
      result.status        = e.hs;
      result.seq_check     = chk;
      result.rtt_us        = (e.hs >= HS_ESTABLISHED) ? e.round_trip : 32'h0;
    end
  end

endmodule

// File: hw/rtl/tst_checker.sv
// Port-level checks on the result channel of the TCP session tracker.
module tst_checker import tst_pkg::*; (
  input logic        clk,
  input logic        rst,
  input logic        res_valid,
  input logic        res_ready,
  input logic        session_found,
  input logic        new_session,
  input logic [63:0] session_id,
  input logic [2:0]  status,
  input logic [1:0]  seq_check,
  input logic [31:0] rtt_us
);

  a_reset_idle: assert property (@(posedge clk) rst |=> !res_valid)
    else $error("result valid after reset");

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(session_id) && $stable(status))
    else $error("stalled result changed");

  a_new_found: assert property (@(posedge clk) disable iff (rst)
    res_valid && new_session |-> session_found && (session_id != 64'd0) &&
      (status == HS_SYN_SENT))
    else $error("new session result inconsistent");

  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    res_valid && !session_found |-> !new_session && (session_id == 64'd0) &&
      (status == HS_UNKNOWN) && (seq_check == CHK_NO_BASE) && (rtt_us == 32'd0))
    else $error("result without session carries data");

  a_rtt_early: assert property (@(posedge clk) disable iff (rst)
    res_valid && ((status == HS_UNKNOWN) || (status == HS_SYN_SENT) ||
      (status == HS_SYNACK_SENT)) |-> (rtt_us == 32'd0))
    else $error("round-trip time reported before establishment");

endmodule

bind tcp_session_tracker_top tst_checker u_tst_checker (
  .clk           (clk),
  .rst           (rst),
  .res_valid     (res.valid),
  .res_ready     (res.ready),
  .session_found (res.session_found),
  .new_session   (res.new_session),
  .session_id    (res.session_id),
  .status        (res.status),
  .seq_check     (res.seq_check),
  .rtt_us        (res.rtt_us)
);

// File: tb/tcp_session_tracker_checker.sv
// Passive scoreboard of the TCP session tracker: predicts each result and compares it.
module tcp_session_tracker_checker import tst_pkg::*; #(
  parameter int SESSION_SLOTS = 1024
) (
  input  logic clk,
  input  logic rst,
  tst_seg_if   seg,
  tst_res_if   res,
  output int   mismatches,
  output int   outstanding
);

  typedef struct {
    bit          live;
    tst_hs_t     hs;
    bit          cli_orient;
    bit          closer_cli;
    bit          cli_has;
    bit [31:0]   cli_base;
    bit [31:0]   cli_next;
    bit          srv_has;
    bit [31:0]   srv_base;
    bit [31:0]   srv_next;
    bit [31:0]   syn_time;
    bit [63:0]   sess_no;
    bit [31:0]   rtt;
  } flow_rec_t;

  flow_rec_t   flows [SESSION_SLOTS];
  bit [63:0]   sessions_opened;
  tst_result_t results_due [$];

  // Relative sequence of one sender against the next byte it owes.
  function automatic tst_chk_t order_check(input bit has, input bit [31:0] base,
                                           inout bit [31:0] nxt, input logic [31:0] seq,
                                           input logic [15:0] len);
    if (!has) return CHK_NO_BASE;
    if (seq - base == nxt) begin
      nxt += 32'(len);
      return CHK_IN_ORDER;
    end
    return CHK_MISMATCH;
  endfunction

  function automatic tst_result_t track_segment(input logic [9:0] slot, input logic orient,
                                                input logic [7:0] raw_flags,
                                                input logic [31:0] seq,
                                                input logic [15:0] len,
                                                input logic [31:0] now);
    int unsigned idx;
    logic [7:0]  fl;
    bit          from_cli;
    bit          made;
    tst_chk_t    chk;
    flow_rec_t   f;
    tst_result_t r;
    idx  = slot % SESSION_SLOTS;
    fl   = raw_flags & FL_KEEP;
    r    = '0;
    made = 1'b0;
    f    = flows[idx];
    if (!f.live) begin
      // Only a bare SYN may claim an empty slot.
      if (fl != FL_SYN) return r;
      sessions_opened++;
      f.live = 1'b1;        f.hs = HS_UNKNOWN;     f.cli_orient = orient;
      f.closer_cli = 1'b0;  f.cli_has = 1'b0;      f.cli_base = '0;
      f.cli_next = '0;      f.srv_has = 1'b0;      f.srv_base = '0;
      f.srv_next = '0;      f.syn_time = '0;       f.sess_no = sessions_opened;
      f.rtt = '0;
      made = 1'b1;
    end
    from_cli = (orient == f.cli_orient);
    if (from_cli) chk = order_check(f.cli_has, f.cli_base, f.cli_next, seq, len);
    else          chk = order_check(f.srv_has, f.srv_base, f.srv_next, seq, len);
    case (f.hs)
      HS_UNKNOWN: begin
        if (fl == FL_SYN && from_cli) begin
          f.hs       = HS_SYN_SENT;
          f.syn_time = now;
          f.cli_has  = 1'b1;
          f.cli_base = seq;
          f.cli_next = 32'd1 + 32'(len);
        end
      end
      HS_SYN_SENT: begin
        if (fl == (FL_SYN | FL_ACK) && !from_cli) begin
          f.hs       = HS_SYNACK_SENT;
          f.srv_has  = 1'b1;
          f.srv_base = seq;
          f.srv_next = 32'd1 + 32'(len);
        end
      end
      HS_SYNACK_SENT: begin
        if (fl == FL_ACK && from_cli) begin
          f.hs  = HS_ESTABLISHED;
          f.rtt = now - f.syn_time;
        end
      end
      HS_ESTABLISHED: begin
        if ((fl & FL_FIN) != 0) begin
          f.hs         = HS_CLOSING;
          f.closer_cli = from_cli;
          if (from_cli) f.cli_next += 1;
          else          f.srv_next += 1;
        end
      end
      HS_CLOSING: begin
        if ((fl & FL_FIN) != 0 && f.closer_cli != from_cli) begin
          f.hs = HS_CLOSED;
          if (from_cli) f.cli_next += 1;
          else          f.srv_next += 1;
        end
      end
      default: ;
    endcase
    flows[idx]      = f;
    r.session_found = 1'b1;
    r.new_session   = made;
    r.session_id    = f.sess_no;
    r.status        = f.hs;
    r.seq_check     = chk;
    r.rtt_us        = (f.hs >= HS_ESTABLISHED) ? f.rtt : 32'd0;
    return r;
  endfunction

  task automatic field_check(input string name, input logic [63:0] want,
                             input logic [63:0] got, inout bit bad);
    if (got !== want) begin
      $display("%0t: %s expected %0h got %0h", $time, name, want, got);
      bad = 1'b1;
    end
  endtask

  task automatic compare_result(input tst_result_t want);
    bit bad;
    bad = 1'b0;
    field_check("session_found", 64'(want.session_found), 64'(res.session_found), bad);
    field_check("new_session", 64'(want.new_session), 64'(res.new_session), bad);
    field_check("session_id", want.session_id, res.session_id, bad);
    field_check("status", 64'(want.status), 64'(res.status), bad);
    field_check("seq_check", 64'(want.seq_check), 64'(res.seq_check), bad);
    field_check("rtt_us", 64'(want.rtt_us), 64'(res.rtt_us), bad);
    if (bad) mismatches++;
  endtask

  always @(posedge clk) begin
    if (rst) begin
      foreach (flows[k]) flows[k].live = 1'b0;
      sessions_opened = '0;
      results_due.delete();
      mismatches = 0;
    end else begin
      if (res.valid && res.ready) begin
        if (results_due.size() == 0) begin
          $display("%0t: result expected none got id %0h status %0d", $time,
                   res.session_id, res.status);
          mismatches++;
        end else begin
          compare_result(results_due.pop_front());
        end
      end
      if (seg.valid && seg.ready)
        results_due.push_back(track_segment(seg.session_slot, seg.orientation,
                                            seg.tcp_flags, seg.seq_number,
                                            seg.segment_length, seg.time_us));
    end
    outstanding = results_due.size();
  end

endmodule

// File: tb/tcp_session_tracker_top_tb.sv
// Testbench top of the TCP session tracker: clock, reset, segment stimulus and verdict.
module tcp_session_tracker_top_tb import tst_pkg::*;;

  localparam int SESSION_SLOTS = 1024;
  // Cycles without any accepted request before the run is abandoned. The count also
  // runs through the clearing pass after reset, which ends within the limit.
  localparam int STALL_LIMIT = 10000;
  localparam int ITEM_TARGET = 900;
  // From this count onwards neither side idles, so the tail runs at full rate.
  localparam int QUIET_FROM = 780;
  localparam logic [7:0] FL_PSH = 8'h08;
  // Flag bits that the tracker masks away: PSH, URG, ECE and CWR.
  localparam logic [7:0] SPARE_FLAGS = 8'hE8;

  logic clk = 1'b0;
  logic rst = 1'b1;

  tst_seg_if seg_ch ();
  tst_res_if res_ch ();

  int          mismatches;
  int          outstanding;
  int          idle_cycles = 0;
  int          sent = 0;
  bit          quiet = 1'b0;
  bit          sender_gaps = 1'b0;
  bit          stalls_on = 1'b0;
  int          stall_left = 0;
  int          window_left = 0;
  logic [31:0] now_us;
  // Slots that a bare SYN has been sent to; the block may hold a session there.
  bit          slot_taken [SESSION_SLOTS];

  always #5 clk = ~clk;

  tcp_session_tracker_top #(.SESSION_SLOTS(SESSION_SLOTS)) i_dut (
    .clk (clk),
    .rst (rst),
    .seg (seg_ch),
    .res (res_ch)
  );

  tcp_session_tracker_checker #(.SESSION_SLOTS(SESSION_SLOTS)) i_check (
    .clk         (clk),
    .rst         (rst),
    .seg         (seg_ch),
    .res         (res_ch),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
  end

  // Result side back-pressure. The run is cut into windows; in some windows the sink
  // stalls in bursts of random length, in the others it is always ready, so stalls
  // land on every phase of the update pipeline.
  always @(posedge clk) begin
    if (rst) begin
      res_ch.ready <= 1'b0;
      stall_left = 0;
      window_left = 0;
    end else begin
      if (window_left == 0) begin
        window_left = 48;
        stalls_on = ($urandom_range(0, 2) != 0);
      end
      window_left--;
      if (stall_left > 0) begin
        res_ch.ready <= 1'b0;
        stall_left--;
      end else if (!quiet && stalls_on && $urandom_range(0, 4) == 0) begin
        res_ch.ready <= 1'b0;
        stall_left = $urandom_range(0, 3);
      end else begin
        res_ch.ready <= 1'b1;
      end
    end
  end

  // Watchdog: any accepted request on either channel restarts the count. A lost
  // result leaves the end of the run waiting forever, which also ends up here.
  always @(posedge clk) begin
    if (rst || (seg_ch.valid && seg_ch.ready) || (res_ch.valid && res_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == STALL_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Extra flag bits that must not change the behaviour, added now and then.
  function automatic logic [7:0] spare_flags();
    logic [7:0] r;
    r = 8'($urandom) & SPARE_FLAGS;
    return ($urandom_range(0, 2) == 0) ? r : 8'h00;
  endfunction

  // Payload lengths: mostly ordinary segment sizes, sometimes empty, rarely the maximum.
  function automatic logic [15:0] payload_bytes();
    case ($urandom_range(0, 19))
      0:       return 16'hFFFF;
      1, 2:    return 16'd0;
      default: return 16'($urandom_range(1, 1460));
    endcase
  endfunction

  // A slot for a new session: usually one never claimed, so the whole handshake
  // is seen; one time in ten any slot at all, which gives collisions.
  function automatic logic [9:0] pick_slot();
    logic [9:0] s;
    int tries;
    s = 10'($urandom_range(0, SESSION_SLOTS - 1));
    if ($urandom_range(0, 9) == 0) return s;
    for (tries = 0; tries < 16 && slot_taken[s]; tries++)
      s = 10'($urandom_range(0, SESSION_SLOTS - 1));
    return s;
  endfunction

  // Offer one segment request and hold it until the block takes it. The call
  // starts and returns at a rising edge; an optional idle burst comes first.
  // Only requests that can reach a session count towards the item total.
  task automatic put(input logic [9:0] slot, input logic orient, input logic [7:0] flags,
                     input logic [31:0] seq, input logic [15:0] len);
    int gap;
    now_us += $urandom_range(1, 4000);
    if (!quiet && sender_gaps && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 4);
      seg_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    seg_ch.valid          <= 1'b1;
    seg_ch.session_slot   <= slot;
    seg_ch.orientation    <= orient;
    seg_ch.tcp_flags      <= flags;
    seg_ch.seq_number     <= seq;
    seg_ch.segment_length <= len;
    seg_ch.time_us        <= now_us;
    @(posedge clk);
    while (!seg_ch.ready) @(posedge clk);
    if (slot_taken[slot] || (flags & FL_KEEP) == FL_SYN) sent++;
    if ((flags & FL_KEEP) == FL_SYN) slot_taken[slot] = 1'b1;
    quiet = (sent >= QUIET_FROM);
  endtask

  // An out-of-place segment inside a handshake: an early ACK from the server, a
  // SYN-ACK in the wrong direction, or a FIN before the session is established.
  task automatic stray(input logic [9:0] slot, input logic orient);
    case ($urandom_range(0, 2))
      0:       put(slot, !orient, FL_ACK, $urandom, 16'd0);
      1:       put(slot, orient, FL_SYN | FL_ACK, $urandom, 16'd0);
      default: put(slot, 1'($urandom_range(0, 1)), FL_FIN, $urandom, 16'd0);
    endcase
  endtask

  // One whole connection on a slot. Index 0 of the sequence arrays is the client,
  // index 1 the server; the server sends with the opposite orientation. Most
  // sessions run from SYN to the second FIN with in-order sequence numbers;
  // some are cut short, some carry stray segments or out-of-order data.
  task automatic run_session(input logic [9:0] slot, input logic orient);
    logic [31:0] isn [2];
    logic [31:0] nxt [2];
    logic [31:0] seq;
    logic [15:0] len;
    int cut, n_data, n_tail, k;
    bit side, closer;
    // Initial sequence numbers close to the top of the range make the
    // relative sequence wrap during the session.
    for (k = 0; k < 2; k++)
      isn[k] = ($urandom_range(0, 4) == 0) ? 32'hFFFF_FFFF - $urandom_range(0, 3000)
                                           : 32'($urandom);
    cut = ($urandom_range(0, 5) == 0) ? $urandom_range(1, 4) : 5;
    n_data = $urandom_range(0, 8);
    n_tail = $urandom_range(0, 2);
    sender_gaps = ($urandom_range(0, 2) != 0);
    // Now and then the capture clock is about to wrap, so the round trip does too.
    if ($urandom_range(0, 9) == 0) now_us = 32'hFFFF_FFFF - $urandom_range(0, 3000);

    len = ($urandom_range(0, 5) == 0) ? 16'($urandom_range(1, 200)) : 16'd0;
    put(slot, orient, FL_SYN | spare_flags(), isn[0], len);
    nxt[0] = 32'd1 + len;
    if (cut == 1) return;
    if ($urandom_range(0, 5) == 0) stray(slot, orient);

    len = ($urandom_range(0, 5) == 0) ? 16'($urandom_range(1, 200)) : 16'd0;
    put(slot, !orient, FL_SYN | FL_ACK | spare_flags(), isn[1], len);
    nxt[1] = 32'd1 + len;
    if (cut == 2) return;
    if ($urandom_range(0, 5) == 0) stray(slot, orient);

    put(slot, orient, FL_ACK, isn[0] + nxt[0], 16'd0);
    if (cut == 3) return;

    // Data in both directions; one segment in eight is out of order and does
    // not move the expected sequence on.
    for (k = 0; k < n_data; k++) begin
      side = $urandom_range(0, 1);
      len  = payload_bytes();
      seq  = isn[side] + nxt[side];
      if ($urandom_range(0, 7) == 0) seq += $urandom_range(1, 5000);
      else                           nxt[side] += len;
      put(slot, orient ^ side,
          ($urandom_range(0, 9) == 0) ? FL_RST : (FL_ACK | FL_PSH | spare_flags()), seq, len);
    end
    if (cut == 4) return;

    // Either side may close first; its FIN takes one sequence number.
    closer = $urandom_range(0, 1);
    len = ($urandom_range(0, 1) == 0) ? payload_bytes() : 16'd0;
    put(slot, orient ^ closer, FL_FIN | FL_ACK, isn[closer] + nxt[closer], len);
    nxt[closer] += len + 32'd1;
    // A repeated FIN from the closer does not complete the close.
    if ($urandom_range(0, 3) == 0)
      put(slot, orient ^ closer, FL_FIN | FL_ACK, isn[closer] + nxt[closer], 16'd0);
    put(slot, orient ^ !closer, FL_FIN | FL_ACK, isn[!closer] + nxt[!closer], 16'd0);
    nxt[!closer] += 32'd1;
    // Segments after the close only get the sequence check.
    for (k = 0; k < n_tail; k++) begin
      side = $urandom_range(0, 1);
      put(slot, orient ^ side, FL_ACK, isn[side] + nxt[side], 16'd0);
    end
  endtask

  initial begin
    int n;
    seg_ch.valid          <= 1'b0;
    seg_ch.session_slot   <= '0;
    seg_ch.orientation    <= 1'b0;
    seg_ch.tcp_flags      <= '0;
    seg_ch.seq_number     <= '0;
    seg_ch.segment_length <= '0;
    seg_ch.time_us        <= '0;
    now_us = 32'hFFFF_FF00;
    @(posedge clk);
    while (rst) @(posedge clk);

    // Directed part. Requests to empty slots that are not a bare SYN, including
    // a flag byte with every bit set, must come back with every field zero.
    put(10'd0, 1'b1, FL_ACK, 32'h0000_1234, 16'd0);
    put(10'd1023, 1'b0, 8'h00, 32'h0000_0000, 16'hFFFF);
    put(10'd0, 1'b1, FL_SYN | FL_ACK, 32'hFFFF_FFFF, 16'd0);
    put(10'd1023, 1'b0, 8'hFF, 32'hFFFF_FFFF, 16'd0);
    // A SYN with the masked bits set still counts as bare and opens session one,
    // with the client sequence base at the very top of the range.
    put(10'd0, 1'b1, FL_SYN | SPARE_FLAGS, 32'hFFFF_FFFF, 16'd0);
    // A retransmitted SYN is out of order against its own base.
    put(10'd0, 1'b1, FL_SYN, 32'hFFFF_FFFF, 16'd0);
    // Server talking before it has a base: no check yet, and no transition.
    put(10'd0, 1'b0, FL_ACK, 32'h0000_0005, 16'd0);
    put(10'd0, 1'b0, FL_SYN | FL_ACK, 32'h0000_0000, 16'd0);
    put(10'd0, 1'b0, FL_ACK, 32'h0000_0001, 16'd10);
    // Final ACK: the relative sequence wraps to one and the round trip becomes visible.
    put(10'd0, 1'b1, FL_ACK, 32'h0000_0000, 16'd0);
    put(10'd0, 1'b1, FL_ACK | FL_PSH, 32'h0000_0000, 16'hFFFF);
    // A reset segment only gets the sequence check.
    put(10'd0, 1'b1, FL_RST, 32'h0000_FFFF, 16'd0);
    // Server closes first, repeats its FIN, then the client completes the close.
    put(10'd0, 1'b0, FL_FIN | FL_ACK, 32'd11, 16'd0);
    put(10'd0, 1'b0, FL_FIN, 32'd11, 16'd0);
    put(10'd0, 1'b1, FL_FIN | FL_ACK, 32'h0000_FFFF, 16'd0);
    put(10'd0, 1'b1, FL_ACK, 32'h0001_0000, 16'd0);
    put(10'd0, 1'b0, FL_SYN, 32'd0, 16'd0);
    // Second session at the top slot; wrong-direction and over-flagged
    // SYN-ACKs do not move it on, the proper one does.
    put(10'd1023, 1'b0, FL_SYN, 32'h7FFF_FFFF, 16'd0);
    put(10'd1023, 1'b0, FL_SYN | FL_ACK, 32'h1000_0000, 16'd0);
    put(10'd1023, 1'b1, FL_FIN | FL_SYN | FL_RST | FL_ACK, 32'h2000_0000, 16'd0);
    put(10'd1023, 1'b1, FL_SYN | FL_ACK, 32'h2000_0000, 16'd0);
    put(10'd1023, 1'b0, FL_ACK, 32'h8000_0000, 16'd0);
    // Third session with a SYN carrying the largest payload.
    put(10'd512, 1'b1, FL_SYN, 32'h8000_0000, 16'hFFFF);
    put(10'd512, 1'b1, FL_ACK, 32'h8001_0000, 16'd0);

    // Random part: mostly whole sessions, with bursts of raw noise that
    // reach any slot with any flag byte.
    while (sent < ITEM_TARGET) begin
      if ($urandom_range(0, 4) == 0) begin
        sender_gaps = $urandom_range(0, 1);
        n = $urandom_range(1, 3);
        repeat (n)
          put(10'($urandom_range(0, SESSION_SLOTS - 1)), 1'($urandom_range(0, 1)),
              8'($urandom), $urandom, 16'($urandom));
      end else begin
        run_session(pick_slot(), 1'($urandom_range(0, 1)));
      end
    end

    seg_ch.valid <= 1'b0;
    @(posedge clk);
    wait (outstanding == 0);
    // Run on so that a spurious extra result would still be seen.
    repeat (8) @(posedge clk);
    if (mismatches == 0) $display("end of test: clean");
    else                 $display("end of test: mismatches");
    $finish;
  end

endmodule
